### hdl/c8x_pkg.sv
// Shared types and constants for the CHIP-8 instruction executor.
// Used by the controller, the datapath and the top level.
package c8x_pkg;

	localparam int MEM_BYTES      = 4096;
	localparam int DISPLAY_WIDTH  = 64;
	localparam int DISPLAY_HEIGHT = 32;

	typedef enum logic [5:0] {
		OP_CLS = 6'd0, OP_RET = 6'd1, OP_JMP = 6'd2, OP_CALL = 6'd3,
		OP_SE_K = 6'd4, OP_SNE_K = 6'd5, OP_SE_R = 6'd6, OP_SNE_R = 6'd7,
		OP_LD_K = 6'd8, OP_ADD_K = 6'd9, OP_LD_R = 6'd10, OP_OR = 6'd11,
		OP_AND = 6'd12, OP_XOR = 6'd13, OP_ADD_R = 6'd14, OP_SUB = 6'd15,
		OP_SHR = 6'd16, OP_SHL = 6'd17, OP_SUBN = 6'd18, OP_LD_I = 6'd19,
		OP_JP_V0 = 6'd20, OP_RND = 6'd21, OP_DRW = 6'd22, OP_LD_VDT = 6'd23,
		OP_LD_VK = 6'd24, OP_LD_DT = 6'd25, OP_LD_ST = 6'd26, OP_ADD_I = 6'd27,
		OP_LD_F = 6'd28, OP_LD_B = 6'd29, OP_ST_REGS = 6'd30, OP_LD_REGS = 6'd31,
		OP_NOP = 6'd32, OP_MEM_WR = 6'd33, OP_FB_RD = 6'd34
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXEC, ST_CLR, ST_BCD, ST_BLK_ST, ST_BLK_RD, ST_BLK_WB,
		ST_DRW_RD, ST_DRW_WAIT, ST_DRW_FB, ST_DRW_WR, ST_FB_RD, ST_FB_WAIT, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_LATCH, CMD_EXEC, CMD_CLR, CMD_BCD, CMD_BLK_ST, CMD_BLK_RD,
		CMD_BLK_WB, CMD_DRW_RD, CMD_DRW_FB, CMD_DRW_WR, CMD_FB_RD, CMD_DONE
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t code;
	} ctl_cmd_t;

	typedef struct packed {
		op_t    op;
		logic   last;
		logic   drw_empty;
	} dp_status_t;

endpackage

### hdl/c8x_ctrl.sv
// Controller state machine for the CHIP-8 instruction executor.
// Depends on c8x_pkg; drives commands into c8x_datapath.
module c8x_ctrl
	import c8x_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output ctl_cmd_t   cmd,
	input  dp_status_t status
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd.code = CMD_NONE;
		busy     = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.code = CMD_LATCH;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (status.op)
					OP_CLS:     state_d = ST_CLR;
					OP_LD_B:    state_d = ST_BCD;
					OP_ST_REGS: state_d = ST_BLK_ST;
					OP_LD_REGS: state_d = ST_BLK_RD;
					OP_DRW:     state_d = status.drw_empty ? ST_DONE : ST_DRW_RD;
					OP_FB_RD:   state_d = ST_FB_RD;
					default: begin
						cmd.code = CMD_EXEC;
						state_d  = ST_DONE;
					end
				endcase
			end
			ST_CLR: begin
				cmd.code = CMD_CLR;
				if (status.last) state_d = ST_DONE;
			end
			ST_BCD: begin
				cmd.code = CMD_BCD;
				if (status.last) state_d = ST_DONE;
			end
			ST_BLK_ST: begin
				cmd.code = CMD_BLK_ST;
				if (status.last) state_d = ST_DONE;
			end
			ST_BLK_RD: begin
				cmd.code = CMD_BLK_RD;
				state_d  = ST_BLK_WB;
			end
			ST_BLK_WB: begin
				cmd.code = CMD_BLK_WB;
				state_d  = status.last ? ST_DONE : ST_BLK_RD;
			end
			ST_DRW_RD: begin
				cmd.code = CMD_DRW_RD;
				state_d  = ST_DRW_WAIT;
			end
			ST_DRW_WAIT: begin
				cmd.code = CMD_DRW_FB;
				state_d  = ST_DRW_FB;
			end
			ST_DRW_FB: begin
				cmd.code = CMD_DRW_WR;
				state_d  = ST_DRW_WR;
			end
			ST_DRW_WR: begin
				cmd.code = CMD_DRW_WR;
				state_d  = status.last ? ST_DONE : ST_DRW_RD;
			end
			ST_FB_RD: begin
				cmd.code = CMD_FB_RD;
				state_d  = ST_FB_WAIT;
			end
			ST_FB_WAIT: state_d = ST_DONE;
			ST_DONE: begin
				cmd.code = CMD_DONE;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### hdl/c8x_datapath.sv
// Datapath of the CHIP-8 instruction executor: registers, stack, RAM, frame buffer.
// Depends on c8x_pkg; sequenced by c8x_ctrl.
module c8x_datapath
	import c8x_pkg::*;
#(
	parameter int FONT_BASE      = 0,
	parameter int STACK_DEPTH    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output dp_status_t  status,
	input  logic [5:0]  mode,
	input  logic [3:0]  reg_x,
	input  logic [3:0]  reg_y,
	input  logic [11:0] immediate,
	input  logic [7:0]  random_byte,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [11:0] next_pc,
	output logic        halted,
	output logic [7:0]  flag_register,
	output logic        display_changed,
	output logic [7:0]  read_data
);

	localparam int MAW     = $clog2(MEM_BYTES);
	localparam int FB_BITS = DISPLAY_WIDTH * DISPLAY_HEIGHT;
	localparam int FB_BYTES = (FB_BITS + 7) / 8;
	localparam int FBW     = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
	localparam int SPW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PBW     = $clog2(FB_BITS + 256 * 2);
	localparam int HW      = $clog2(DISPLAY_HEIGHT) + 1;

	logic [7:0]      v_q [16];
	logic [11:0]     pc_q;
	logic [15:0]     i_q;
	logic [11:0]     stk_q [STACK_DEPTH];
	logic [SPW-1:0]  sp_q;
	logic [7:0]      dt_q, st_q;
	logic            halt_q;
	logic            chg_q;
	logic [7:0]      rd_q;

	logic [7:0]      mem_q [MEM_BYTES];
	logic [7:0]      fb_q  [FB_BYTES];
	logic [FB_BYTES-1:0] fb_vld_q;

	op_t             op_q;
	logic [3:0]      x_q, y_q;
	logic [11:0]     imm_q;
	logic [7:0]      rnd_q, wd_q;
	logic [7:0]      vx_q, vy_q;
	logic [4:0]      cnt_q;
	logic            erase_q;

	logic            mem_we;
	logic [MAW-1:0]  mem_wa, mem_ra;
	logic [7:0]      mem_wd;
	logic [7:0]      mem_rd_q;

	logic [FBW-1:0]  fb_ra, fb_wa;
	logic            fb_we;
	logic [7:0]      fb_wd;
	logic [7:0]      fb_rd_q;
	logic            fb_rvld_q;

	logic [PBW-1:0]  pbase_q;
	logic [15:0]     sbits_q;

	logic [4:0]      off_w;
	logic [MAW-1:0]  i_off;
	logic [7:0]      bcd_h, bcd_t, bcd_o;
	logic [HW-1:0]   row_w;
	logic [PBW-1:0]  pbase_w;
	logic [PBW-1:0]  pbyte;
	logic [SPW-1:0]  sp_inc, sp_dec;

	assign off_w = (op_q == OP_DRW) ? {1'b0, cnt_q[4:1]} : cnt_q;
	assign i_off = MAW'(i_q + 16'(off_w));

	assign sp_inc = (sp_q == SPW'(STACK_DEPTH - 1)) ? '0 : sp_q + SPW'(1);
	assign sp_dec = (sp_q == '0) ? SPW'(STACK_DEPTH - 1) : sp_q - SPW'(1);

	always_comb begin
		logic [7:0] r;
		r     = vx_q;
		bcd_h = 8'd0;
		if (r >= 8'd200) begin bcd_h = 8'd2; r = r - 8'd200; end
		else if (r >= 8'd100) begin bcd_h = 8'd1; r = r - 8'd100; end
		bcd_t = 8'((16'(r) * 16'd205) >> 11);
		bcd_o = r - 8'(bcd_t * 8'd10);
	end

	always_comb begin
		logic [HW:0] s;
		s = (HW + 1)'(vy_q % DISPLAY_HEIGHT) + (HW + 1)'(off_w);
		if (s >= (HW + 1)'(DISPLAY_HEIGHT)) s = s - (HW + 1)'(DISPLAY_HEIGHT);
		row_w   = HW'(s);
		pbase_w = PBW'(vx_q) + PBW'(row_w) * PBW'(DISPLAY_WIDTH);
	end

	assign pbyte = pbase_q >> 3;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = i_off;
		mem_wd = v_q[cnt_q[3:0]];
		mem_ra = i_off;
		unique case (cmd.code)
			CMD_BCD: begin
				mem_we = 1'b1;
				mem_wd = (cnt_q == 5'd0) ? bcd_h : (cnt_q == 5'd1) ? bcd_t : bcd_o;
			end
			CMD_BLK_ST: mem_we = 1'b1;
			CMD_EXEC: begin
				if (op_q == OP_MEM_WR) begin
					mem_we = 1'b1;
					mem_wa = MAW'(imm_q % MEM_BYTES);
					mem_wd = wd_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		mem_rd_q <= mem_q[mem_ra];
	end

	logic [7:0] fb_rdat;
	assign fb_rdat = fb_rvld_q ? fb_rd_q : 8'd0;

	always_comb begin
		fb_ra = FBW'(imm_q % FB_BYTES);
		fb_we = 1'b0;
		fb_wa = FBW'(pbyte);
		fb_wd = 8'd0;
		unique case (cmd.code)
			CMD_DRW_FB: fb_ra = FBW'(pbyte);
			CMD_DRW_WR: begin
				if (cnt_q[0] == 1'b0) begin
					fb_ra = FBW'(pbyte + PBW'(1));
					fb_wa = FBW'(pbyte);
					fb_wd = fb_rdat ^ sbits_q[15:8];
					fb_we = (pbyte < PBW'(FB_BYTES));
				end else begin
					fb_wa = FBW'(pbyte + PBW'(1));
					fb_wd = fb_rdat ^ sbits_q[7:0];
					fb_we = (pbyte + PBW'(1) < PBW'(FB_BYTES));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fb_we) fb_q[fb_wa] <= fb_wd;
		fb_rd_q <= fb_q[fb_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_vld_q  <= '0;
			fb_rvld_q <= 1'b0;
		end else begin
			fb_rvld_q <= fb_vld_q[fb_ra];
			if (cmd.code == CMD_CLR && cnt_q == 5'd0) fb_vld_q <= '0;
			else if (fb_we) fb_vld_q[fb_wa] <= 1'b1;
		end
	end

	logic [8:0]  sum_xy;
	logic [8:0]  sum_xk;

	assign sum_xy = {1'b0, vx_q} + {1'b0, vy_q};
	assign sum_xk = {1'b0, vx_q} + {1'b0, imm_q[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) v_q[k] <= 8'd0;
			pc_q    <= '0;
			i_q     <= '0;
			sp_q    <= '0;
			dt_q    <= '0;
			st_q    <= '0;
			halt_q  <= 1'b0;
			chg_q   <= 1'b0;
			rd_q    <= '0;
			op_q    <= OP_NOP;
			cnt_q   <= '0;
			erase_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (cmd.code)
				CMD_LATCH: begin
					op_q    <= op_t'(mode);
					x_q     <= reg_x;
					y_q     <= reg_y;
					imm_q   <= immediate;
					rnd_q   <= random_byte;
					wd_q    <= write_data;
					vx_q    <= v_q[reg_x];
					vy_q    <= v_q[reg_y];
					cnt_q   <= '0;
					erase_q <= 1'b0;
					rd_q    <= '0;
					chg_q   <= 1'b0;
				end
				CMD_EXEC: begin
					unique case (op_q)
						OP_RET: begin
							pc_q <= stk_q[sp_q] - 12'd2;
							sp_q <= sp_dec;
						end
						OP_JMP: begin
							if (pc_q == imm_q) halt_q <= 1'b1;
							pc_q <= imm_q - 12'd2;
						end
						OP_CALL: begin
							sp_q <= sp_inc;
							stk_q[sp_inc] <= pc_q + 12'd2;
							pc_q <= imm_q - 12'd2;
						end
						OP_SE_K:  if (vx_q == imm_q[7:0]) pc_q <= pc_q + 12'd2;
						OP_SNE_K: if (vx_q != imm_q[7:0]) pc_q <= pc_q + 12'd2;
						OP_SE_R:  if (vx_q == vy_q) pc_q <= pc_q + 12'd2;
						OP_SNE_R: if (vx_q != vy_q) pc_q <= pc_q + 12'd2;
						OP_LD_K:  v_q[x_q] <= imm_q[7:0];
						OP_ADD_K: v_q[x_q] <= sum_xk[7:0];
						OP_LD_R:  v_q[x_q] <= vy_q;
						OP_OR:    v_q[x_q] <= vx_q | vy_q;
						OP_AND:   v_q[x_q] <= vx_q & vy_q;
						OP_XOR:   v_q[x_q] <= vx_q ^ vy_q;
						OP_ADD_R: begin
							if (x_q != 4'd15) v_q[x_q] <= sum_xy[7:0];
							v_q[15]  <= {7'd0, sum_xy[8]};
						end
						OP_SUB: begin
							if (x_q != 4'd15) v_q[x_q] <= vx_q - vy_q;
							v_q[15]  <= {7'd0, vx_q > vy_q};
						end
						OP_SHR: begin
							if (x_q != 4'd15) v_q[x_q] <= vx_q >> 1;
							v_q[15]  <= {7'd0, vx_q[0]};
						end
						OP_SHL: begin
							if (x_q != 4'd15) v_q[x_q] <= vx_q << 1;
							v_q[15]  <= {7'd0, vx_q[7]};
						end
						OP_SUBN: begin
							if (x_q != 4'd15) v_q[x_q] <= vy_q - vx_q;
							v_q[15]  <= {7'd0, vy_q > vx_q};
						end
						OP_LD_I:   i_q <= {4'd0, imm_q};
						OP_JP_V0:  pc_q <= imm_q + {4'd0, v_q[0]} - 12'd2;
						OP_RND:    v_q[x_q] <= rnd_q & imm_q[7:0];
						OP_LD_VDT: v_q[x_q] <= dt_q;
						OP_LD_VK:  v_q[x_q] <= 8'd0;
						OP_LD_DT:  dt_q <= vx_q;
						OP_LD_ST:  st_q <= vx_q;
						OP_ADD_I:  i_q <= i_q + {8'd0, vx_q};
						OP_LD_F:   i_q <= 16'(FONT_BASE) + 16'(vx_q) * 16'd5;
						default: ;
					endcase
				end
				CMD_CLR, CMD_BCD, CMD_BLK_ST: cnt_q <= cnt_q + 5'd1;
				CMD_BLK_WB: begin
					v_q[cnt_q[3:0]] <= mem_rd_q;
					cnt_q <= cnt_q + 5'd1;
				end
				CMD_DRW_RD: begin
					pbase_q <= pbase_w;
				end
				CMD_DRW_FB: begin
					sbits_q <= {mem_rd_q, 8'd0} >> pbase_q[2:0];
				end
				CMD_DRW_WR: begin
					if (cnt_q[0] == 1'b0) begin
						if ((fb_rdat & sbits_q[15:8]) != 8'd0 && pbyte < PBW'(FB_BYTES))
							erase_q <= 1'b1;
					end else begin
						if ((fb_rdat & sbits_q[7:0]) != 8'd0 &&
							pbyte + PBW'(1) < PBW'(FB_BYTES))
							erase_q <= 1'b1;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				CMD_FB_RD: ;
				CMD_DONE: begin
					done <= 1'b1;
					if (op_q == OP_FB_RD) rd_q <= fb_rdat;
					if (op_q == OP_DRW) begin
						v_q[15] <= {7'd0, erase_q};
						chg_q   <= 1'b1;
					end
					if (op_q <= OP_NOP) pc_q <= pc_q + 12'd2;
				end
				default: ;
			endcase
		end
	end

	assign status.op        = op_q;
	assign status.drw_empty = (imm_q[3:0] == 4'd0);
	always_comb begin
		unique case (op_q)
			OP_CLS:     status.last = 1'b1;
			OP_LD_B:    status.last = (cnt_q == 5'd2);
			OP_ST_REGS, OP_LD_REGS: status.last = (cnt_q[3:0] == x_q);
			OP_DRW:     status.last = (cnt_q[4:1] == imm_q[3:0] - 4'd1) && cnt_q[0];
			default:    status.last = 1'b1;
		endcase
	end

	assign next_pc         = pc_q;
	assign halted          = halt_q;
	assign flag_register   = v_q[15];
	assign display_changed = chg_q;
	assign read_data       = rd_q;

endmodule

### hdl/chip8_instruction_executor.sv
// CHIP-8 instruction executor, one request at a time; busy is high from accept to result.
// CLS, frame buffer read, LD B, block store, block load (a read and a write-back per
// register) and DRW (per sprite row: sprite read, frame buffer read, write of both bytes)
// step through more states than other instructions; a new request is taken in the
// strobe cycle. Result strobe (done) is high one cycle; the receiver cannot stall.
// Reset clears registers, PC, stack pointer, timers and frame buffer at once.
module chip8_instruction_executor
	import c8x_pkg::*;
#(
	parameter int FONT_BASE      = 0,
	parameter int STACK_DEPTH    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [5:0]  mode,
	input  logic [3:0]  reg_x,
	input  logic [3:0]  reg_y,
	input  logic [11:0] immediate,
	input  logic [7:0]  random_byte,
	input  logic [7:0]  write_data,
	output logic [11:0] next_pc,
	output logic        halted,
	output logic [7:0]  flag_register,
	output logic        display_changed,
	output logic [7:0]  read_data
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	c8x_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .status(status)
	);

	c8x_datapath #(
		.FONT_BASE(FONT_BASE), .STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.mode(mode), .reg_x(reg_x), .reg_y(reg_y), .immediate(immediate),
		.random_byte(random_byte), .write_data(write_data), .done(done),
		.next_pc(next_pc), .halted(halted), .flag_register(flag_register),
		.display_changed(display_changed), .read_data(read_data)
	);

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy == 1'b0) else $error("result while busy");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halted) |-> halted) else $error("halt cleared");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("double result");

endmodule

### tb/tb_top.sv
// Self-checking testbench for chip8_instruction_executor.
// Builds a request stream up front, predicts each result with an in-bench machine
// model, and drives, monitors and checks the block. Depends on hdl/c8x_pkg.sv.
`timescale 1ns / 100ps

module tb_top
	import c8x_pkg::*;
;

	typedef struct packed {
		logic [5:0]  mode;
		logic [3:0]  x;
		logic [3:0]  y;
		logic [11:0] imm;
		logic [7:0]  rnd;
		logic [7:0]  wd;
	} instr_t;

	typedef struct packed {
		logic [11:0] pc;
		logic        halt;
		logic [7:0]  vf;
		logic        chg;
		logic [7:0]  rd;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        done;
	logic [5:0]  mode;
	logic [3:0]  reg_x;
	logic [3:0]  reg_y;
	logic [11:0] immediate;
	logic [7:0]  random_byte;
	logic [7:0]  write_data;
	logic [11:0] next_pc;
	logic        halted;
	logic [7:0]  flag_register;
	logic        display_changed;
	logic [7:0]  read_data;

	chip8_instruction_executor dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.mode(mode), .reg_x(reg_x), .reg_y(reg_y), .immediate(immediate),
		.random_byte(random_byte), .write_data(write_data), .next_pc(next_pc),
		.halted(halted), .flag_register(flag_register),
		.display_changed(display_changed), .read_data(read_data)
	);

	// machine copy
	logic [7:0]  vreg [16];
	logic [11:0] pc_m;
	logic [15:0] idx_m;
	logic [11:0] stk [16];
	logic        stk_ok [16];
	logic [3:0]  sp_m;
	logic [7:0]  dt_m;
	logic [7:0]  st_m;
	logic [7:0]  ram [4096];
	logic        ram_ok [4096];
	logic [7:0]  fbuf [256];
	logic        halt_m;

	instr_t   pending [$];
	outcome_t expected [$];
	int       errors;
	int       gap;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [11:0] ram_at(int off);
		return 12'((idx_m + off) % 4096);
	endfunction

	function automatic outcome_t execute(instr_t it);
		outcome_t r;
		logic [7:0] vx;
		logic [7:0] vy;
		logic [7:0] kk;
		logic [11:0] pc;
		int adv;
		logic erased;
		int row;
		int p;
		logic [7:0] bits;
		vx = vreg[it.x];
		vy = vreg[it.y];
		kk = it.imm[7:0];
		pc = pc_m;
		adv = 2;
		r.rd = 8'd0;
		r.chg = 1'b0;
		case (it.mode)
			OP_CLS: for (int i = 0; i < 256; i++) fbuf[i] = 8'd0;
			OP_RET: begin
				pc = stk[sp_m];
				adv = 0;
				sp_m = sp_m - 4'd1;
			end
			OP_JMP: begin
				if (pc == it.imm) halt_m = 1'b1;
				pc = it.imm;
				adv = 0;
			end
			OP_CALL: begin
				sp_m = sp_m + 4'd1;
				stk[sp_m] = pc + 12'd2;
				stk_ok[sp_m] = 1'b1;
				pc = it.imm;
				adv = 0;
			end
			OP_SE_K: if (vx == kk) adv = 4;
			OP_SNE_K: if (vx != kk) adv = 4;
			OP_SE_R: if (vx == vy) adv = 4;
			OP_SNE_R: if (vx != vy) adv = 4;
			OP_LD_K: vreg[it.x] = kk;
			OP_ADD_K: vreg[it.x] = vx + kk;
			OP_LD_R: vreg[it.x] = vy;
			OP_OR: vreg[it.x] = vx | vy;
			OP_AND: vreg[it.x] = vx & vy;
			OP_XOR: vreg[it.x] = vx ^ vy;
			OP_ADD_R: begin
				vreg[it.x] = vx + vy;
				vreg[15] = 8'(({1'b0, vx} + {1'b0, vy}) > 9'd255);
			end
			OP_SUB: begin
				vreg[it.x] = vx - vy;
				vreg[15] = 8'(vx > vy);
			end
			OP_SHR: begin
				vreg[it.x] = vx >> 1;
				vreg[15] = 8'(vx[0]);
			end
			OP_SHL: begin
				vreg[it.x] = vx << 1;
				vreg[15] = 8'(vx[7]);
			end
			OP_SUBN: begin
				vreg[it.x] = vy - vx;
				vreg[15] = 8'(vy > vx);
			end
			OP_LD_I: idx_m = 16'(it.imm);
			OP_JP_V0: begin
				pc = 12'(vreg[0]) + it.imm;
				adv = 0;
			end
			OP_RND: vreg[it.x] = it.rnd & kk;
			OP_DRW: begin
				erased = 1'b0;
				for (int i = 0; i < int'(it.imm[3:0]); i++) begin
					bits = ram[ram_at(i)];
					row = (int'(vy) + i) % 32;
					for (int b = 0; b < 8; b++) begin
						p = int'(vx) + row * 64 + b;
						if (bits[7 - b] && p < 2048) begin
							if (fbuf[p / 8][7 - p % 8]) erased = 1'b1;
							fbuf[p / 8][7 - p % 8] ^= 1'b1;
						end
					end
				end
				vreg[15] = 8'(erased);
				r.chg = 1'b1;
			end
			OP_LD_VDT: vreg[it.x] = dt_m;
			OP_LD_VK: vreg[it.x] = 8'd0;
			OP_LD_DT: dt_m = vx;
			OP_LD_ST: st_m = vx;
			OP_ADD_I: idx_m = idx_m + 16'(vx);
			OP_LD_F: idx_m = 16'(vx) * 16'd5;
			OP_LD_B: begin
				ram[ram_at(0)] = vx / 100;
				ram[ram_at(1)] = (vx / 10) % 10;
				ram[ram_at(2)] = vx % 10;
				for (int k = 0; k < 3; k++) ram_ok[ram_at(k)] = 1'b1;
			end
			OP_ST_REGS: for (int k = 0; k <= int'(it.x); k++) begin
				ram[ram_at(k)] = vreg[k];
				ram_ok[ram_at(k)] = 1'b1;
			end
			OP_LD_REGS: for (int k = 0; k <= int'(it.x); k++) vreg[k] = ram[ram_at(k)];
			OP_NOP: ;
			OP_MEM_WR: begin
				ram[it.imm] = it.wd;
				ram_ok[it.imm] = 1'b1;
				adv = 0;
			end
			OP_FB_RD: begin
				r.rd = fbuf[it.imm[7:0]];
				adv = 0;
			end
			default: adv = 0;
		endcase
		pc_m = pc + 12'(adv);
		r.pc = pc_m;
		r.halt = halt_m;
		r.vf = vreg[15];
		return r;
	endfunction

	// queue a request, filling unwritten memory or replacing an empty return first
	task automatic issue(instr_t it);
		instr_t fill;
		int reads;
		if (it.mode == OP_RET && !stk_ok[sp_m]) it.mode = OP_CALL;
		reads = 0;
		if (it.mode == OP_DRW) reads = int'(it.imm[3:0]);
		if (it.mode == OP_LD_REGS) reads = int'(it.x) + 1;
		for (int k = 0; k < reads; k++) begin
			if (!ram_ok[ram_at(k)]) begin
				fill = '0;
				fill.mode = OP_MEM_WR;
				fill.imm = ram_at(k);
				fill.wd = 8'($urandom);
				fill.x = 4'($urandom);
				expected.push_back(execute(fill));
				pending.push_back(fill);
			end
		end
		expected.push_back(execute(it));
		pending.push_back(it);
	endtask

	task automatic directed(op_t op, int x, int y, int imm);
		instr_t it;
		it.mode = op;
		it.x = 4'(x);
		it.y = 4'(y);
		it.imm = 12'(imm);
		it.rnd = 8'($urandom);
		it.wd = 8'($urandom);
		issue(it);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= '0;
			reg_x <= '0;
			reg_y <= '0;
			immediate <= '0;
			random_byte <= '0;
			write_data <= '0;
			gap <= 0;
		end else if (!start || !busy) begin
			if (gap > 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (pending.size() > 0) begin
				start <= 1'b1;
				mode <= pending[0].mode;
				reg_x <= pending[0].x;
				reg_y <= pending[0].y;
				immediate <= pending[0].imm;
				random_byte <= pending[0].rnd;
				write_data <= pending[0].wd;
				void'(pending.pop_front());
				if (pending.size() > 100 && $urandom_range(0, 5) == 0)
					gap <= $urandom_range(1, 13);
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (expected.size() == 0) begin
				report_mismatch("unexpected result pc", next_pc, 0);
			end else begin
				want = expected.pop_front();
				if (next_pc !== want.pc) report_mismatch("next_pc", next_pc, want.pc);
				if (halted !== want.halt) report_mismatch("halted", halted, want.halt);
				if (flag_register !== want.vf)
					report_mismatch("flag_register", flag_register, want.vf);
				if (display_changed !== want.chg)
					report_mismatch("display_changed", display_changed, want.chg);
				if (read_data !== want.rd) report_mismatch("read_data", read_data, want.rd);
			end
		end
	end

	initial begin
		instr_t it;
		int m;
		errors = 0;
		for (int i = 0; i < 16; i++) begin
			vreg[i] = 8'd0;
			stk[i] = 12'd0;
			stk_ok[i] = 1'b0;
		end
		for (int i = 0; i < 4096; i++) begin
			ram[i] = 8'd0;
			ram_ok[i] = 1'b0;
		end
		for (int i = 0; i < 256; i++) fbuf[i] = 8'd0;
		pc_m = '0;
		idx_m = '0;
		sp_m = '0;
		dt_m = '0;
		st_m = '0;
		halt_m = 1'b0;

		directed(OP_LD_K, 0, 0, 'hFF);
		directed(OP_LD_K, 15, 0, 'h81);
		directed(OP_ADD_R, 15, 0, 0);
		directed(OP_SUB, 1, 0, 0);
		directed(OP_SUBN, 2, 0, 0);
		directed(OP_SHL, 0, 0, 0);
		directed(OP_SHR, 15, 0, 0);
		directed(OP_SE_K, 1, 0, 0);
		directed(OP_SNE_R, 1, 0, 0);
		directed(OP_CALL, 0, 0, 'hFFE);
		directed(OP_RET, 0, 0, 0);
		directed(OP_JP_V0, 0, 0, 'hFFF);
		directed(OP_RND, 3, 0, 'h0F0);
		directed(OP_LD_I, 0, 0, 'hFFE);
		directed(OP_LD_K, 4, 0, 63);
		directed(OP_LD_K, 5, 0, 31);
		directed(OP_DRW, 4, 5, 15);
		directed(OP_DRW, 4, 5, 15);
		directed(OP_LD_B, 0, 0, 0);
		directed(OP_ST_REGS, 15, 0, 0);
		directed(OP_LD_REGS, 15, 0, 0);
		directed(OP_LD_DT, 0, 0, 0);
		directed(OP_LD_VDT, 6, 0, 0);
		directed(OP_LD_F, 0, 0, 0);
		directed(OP_MEM_WR, 0, 0, 'hFFF);
		directed(OP_FB_RD, 0, 0, 'hFFF);
		directed(OP_CLS, 0, 0, 0);
		directed(op_t'(6'd63), 0, 0, 0);

		for (int n = 0; n < 1000; n++) begin
			m = $urandom_range(0, 99);
			if (m < 3) it.mode = 6'($urandom_range(35, 63));
			else if (m < 20) it.mode = OP_DRW;
			else it.mode = 6'($urandom_range(0, 34));
			it.x = 4'($urandom);
			it.y = 4'($urandom);
			it.imm = 12'($urandom);
			it.rnd = 8'($urandom);
			it.wd = 8'($urandom);
			if (it.mode == OP_JMP && it.imm == pc_m) it.imm = it.imm + 12'd1;
			issue(it);
		end
		directed(OP_JMP, 0, 0, 'h200);
		directed(OP_JMP, 0, 0, 'h200);
		directed(OP_NOP, 0, 0, 0);

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (expected.size() == 0 && pending.size() == 0);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
